### design/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types and constants for the trial-division prime counter.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // width of a tested value once the sign is known to be clear
  localparam int NVAL_W = 31;
  // divisor and remainder width (largest divisor tried is below 2^16)
  localparam int DIV_W  = 16;
  // running count width
  localparam int CNT_W  = 15;
  // square of the divisor
  localparam int SQ_W   = 32;
  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // classification made by the front end
  typedef enum logic [1:0] {
    KIND_NOT   = 2'd0,   // negative, zero, one or even above two
    KIND_TWO   = 2'd1,   // the value two
    KIND_TRIAL = 2'd2    // odd, three or more: needs trial division
  } kind_t;

  // one queued request
  typedef struct packed {
    logic [NVAL_W-1:0] value;
    logic              last;
    kind_t             kind;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // back end sequencer
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_TEST = 2'd1,
    ST_DIV  = 2'd2,
    ST_EMIT = 2'd3
  } bstate_t;

endpackage

### design/pctd_front.sv
// ----------------------------------------------------------------------------
// pctd_front
// Input stage: takes a request, classifies its value and hands it to the queue.
// ----------------------------------------------------------------------------
module pctd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [31:0] value
  input  logic                 s_tlast,
  input  pctd_pkg::qstat_t     qstat,
  output logic                 push,
  output pctd_pkg::item_t      push_item
);
  import pctd_pkg::*;

  logic  held;
  item_t item;
  kind_t kind_new;
  logic  take;

  // classify the incoming value
  always_comb begin
    if (s_tdata[31] || (s_tdata[31:1] == 31'd0)) begin
      kind_new = KIND_NOT;
    end else if (s_tdata == 32'd2) begin
      kind_new = KIND_TWO;
    end else if (!s_tdata[0]) begin
      kind_new = KIND_NOT;
    end else begin
      kind_new = KIND_TRIAL;
    end
  end

  assign push      = held && !qstat.full;
  assign s_tready  = !held || !qstat.full;
  assign take      = s_tvalid && s_tready;
  assign push_item = item;

  // holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.value <= s_tdata[NVAL_W-1:0];
      item.last  <= s_tlast;
      item.kind  <= kind_new;
    end
  end

endmodule

### design/pctd_queue.sv
// ----------------------------------------------------------------------------
// pctd_queue
// Short first-in first-out queue of classified requests.
// ----------------------------------------------------------------------------
module pctd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pctd_pkg::item_t  push_item,
  input  logic             pop,
  output pctd_pkg::item_t  pop_item,
  output pctd_pkg::qstat_t qstat
);
  import pctd_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign qstat.full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign qstat.empty = (fill == '0);
  assign pop_item    = slots[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### design/pctd_back.sv
// ----------------------------------------------------------------------------
// pctd_back
// Trial division engine, running count and output register.
// ----------------------------------------------------------------------------
module pctd_back #(
  parameter int MAX_ELEMENTS = 16384
) (
  input  logic             clk,
  input  logic             rst,
  input  pctd_pkg::qstat_t qstat,
  input  pctd_pkg::item_t  pop_item,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,   // [0] is_prime, [15:1] prime_count
  output logic             m_tlast
);
  import pctd_pkg::*;

  localparam int CountLimit = (MAX_ELEMENTS > 32767) ? 32767 : MAX_ELEMENTS;

  bstate_t           state, state_next;
  logic [NVAL_W-1:0] n, n_next;
  logic [SQ_W-1:0]   sh, sh_next;
  logic [DIV_W-1:0]  d, d_next;
  logic [SQ_W-1:0]   sq, sq_next;
  logic [DIV_W-1:0]  r, r_next;
  logic [3:0]        pc, pc_next;
  logic              last_q, last_next;
  logic              prime_q, prime_next;
  logic [CNT_W-1:0]  run_cnt, run_cnt_next;
  logic              out_valid, out_valid_next;
  logic              out_prime, out_prime_next;
  logic [CNT_W-1:0]  out_count, out_count_next;
  logic              out_last, out_last_next;
  logic              out_free;
  logic [DIV_W-1:0]  r_half;
  logic [DIV_W-1:0]  r_full;
  logic [CNT_W-1:0]  cnt_inc;

  // one restoring division step: shift in a bit, subtract if it fits
  function automatic logic [DIV_W-1:0] rem_step(input logic [DIV_W-1:0] rem,
                                                input logic               b,
                                                input logic [DIV_W-1:0] dv);
    logic [DIV_W:0] t;
    logic [DIV_W:0] diff;
    t    = {rem, b};
    diff = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return diff[DIV_W-1:0];
    end
    return t[DIV_W-1:0];
  endfunction

  // two quotient bits per cycle
  assign r_half = rem_step(r, sh[SQ_W-1], d);
  assign r_full = rem_step(r_half, sh[SQ_W-2], d);

  assign out_free = !out_valid || m_tready;
  assign cnt_inc  = (prime_q && (run_cnt < CNT_W'(CountLimit))) ? run_cnt + 1'b1 : run_cnt;

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_count, out_prime};
  assign m_tlast  = out_last;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      run_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      run_cnt   <= run_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n         <= n_next;
    sh        <= sh_next;
    d         <= d_next;
    sq        <= sq_next;
    r         <= r_next;
    pc        <= pc_next;
    last_q    <= last_next;
    prime_q   <= prime_next;
    out_prime <= out_prime_next;
    out_count <= out_count_next;
    out_last  <= out_last_next;
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_next     = state;
    n_next         = n;
    sh_next        = sh;
    d_next         = d;
    sq_next        = sq;
    r_next         = r;
    pc_next        = pc;
    last_next      = last_q;
    prime_next     = prime_q;
    run_cnt_next   = run_cnt;
    out_valid_next = out_valid && !m_tready;
    out_prime_next = out_prime;
    out_count_next = out_count;
    out_last_next  = out_last;
    pop            = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          n_next    = pop_item.value;
          last_next = pop_item.last;
          d_next    = DIV_W'(3);
          sq_next   = SQ_W'(9);
          unique case (pop_item.kind)
            KIND_TRIAL: begin
              state_next = ST_TEST;
            end
            KIND_TWO: begin
              prime_next = 1'b1;
              state_next = ST_EMIT;
            end
            default: begin
              prime_next = 1'b0;
              state_next = ST_EMIT;
            end
          endcase
        end
      end
      ST_TEST: begin
        // divisor squared past the value: no factor left
        if (sq > {1'b0, n}) begin
          prime_next = 1'b1;
          state_next = ST_EMIT;
        end else begin
          r_next     = '0;
          sh_next    = {1'b0, n};
          pc_next    = '1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        r_next  = r_full;
        sh_next = {sh[SQ_W-3:0], 2'b00};
        pc_next = pc - 1'b1;
        if (pc == '0) begin
          if (r_full == '0) begin
            prime_next = 1'b0;
            state_next = ST_EMIT;
          end else begin
            // next odd divisor, square kept by (d+2)^2 = d^2 + 4d + 4
            d_next     = d + DIV_W'(2);
            sq_next    = sq + SQ_W'({d, 2'b00}) + SQ_W'(4);
            state_next = ST_TEST;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_prime_next = prime_q;
          out_count_next = cnt_inc;
          out_last_next  = last_q;
          run_cnt_next   = last_q ? '0 : cnt_inc;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/prime_count_trial_division.sv
// ----------------------------------------------------------------------------
// prime_count_trial_division
// Streams signed 32-bit values, flags primes and counts them per set.
// ----------------------------------------------------------------------------
// Each request carries one value (s_tdata) and a last-of-set mark (s_tlast);
// each one gives exactly one result with the prime flag, the running prime
// count of the set including this value, and the echoed mark on m_tlast.
// The count clears after the result of a last-marked request and saturates
// at the smaller of MAX_ELEMENTS and 32767. Values that are negative, below
// two or even go straight to the result; an odd value is tested against odd
// divisors from 3 upward until one divides it or the divisor's square passes
// the value (at most about 23170 divisors for a large prime). Each divisor
// takes one test step and then a remainder unit that retires two bits per
// cycle. A four-entry queue lets the input side keep taking requests while
// the back end is busy, and the output register lets the back end move on
// while a result waits to be taken.
module prime_count_trial_division #(
  parameter int MAX_ELEMENTS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [0] is_prime, [15:1] prime_count
  output logic        m_tlast
);
  import pctd_pkg::*;

  qstat_t qstat;
  item_t  push_item;
  item_t  pop_item;
  logic   push;
  logic   pop;

  // classification
  pctd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  pctd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // trial division and counting
  pctd_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .pop_item (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### design/pctd_checker.sv
// ----------------------------------------------------------------------------
// pctd_checker
// Port-level checks of the prime counter's result stream.
// ----------------------------------------------------------------------------
module pctd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  logic        m_tlast
);
  import pctd_pkg::*;

  logic [CNT_W-1:0] prev_cnt;
  logic             out_take;
  logic             in_take;
  logic [CNT_W:0]   prev_inc;
  logic [3:0]       in_flight;

  assign out_take = m_tvalid && m_tready;
  assign in_take  = s_tvalid && s_tready;
  assign prev_inc = {1'b0, prev_cnt} + 1'b1;

  // count carried from the previous result of the same set
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cnt <= '0;
    end else if (out_take) begin
      prev_cnt <= m_tlast ? '0 : m_tdata[15:1];
    end
  end

  // requests taken and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else if (in_take && !out_take) begin
      in_flight <= in_flight + 1'b1;
    end else if (out_take && !in_take) begin
      in_flight <= in_flight - 1'b1;
    end
  end

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a non-prime leaves the count unchanged
  a_keep: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[15:1] == prev_cnt)
    else $error("count moved on a non-prime");

  // a prime raises the count by one or it is saturated
  a_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |->
      ({1'b0, m_tdata[15:1]} == prev_inc) || (m_tdata[15:1] == prev_cnt))
    else $error("count step wrong on a prime");

  // a result always answers an earlier request
  a_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> in_flight != '0)
    else $error("result with no request outstanding");

endmodule

bind prime_count_trial_division pctd_checker u_pctd_checker (.*);

### tb/sv/prime_count_trial_division_tb.sv
// ----------------------------------------------------------------------------
// prime_count_trial_division_tb
// Self-checking bench for the trial-division prime counter.
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus block fills and a clocked
// driver drains; a clocked monitor predicts the prime flag and the per-set
// running count for every accepted request and checks each result in order.
// Stimulus covers directed corner values and random values shaped to keep
// the trial-division loop short, run under several sender-idle and
// receiver-stall mixes.
module prime_count_trial_division_tb;
  import pctd_pkg::*;

  localparam int MAX_ELEMENTS = 16384;
  localparam int COUNT_LIMIT  = (MAX_ELEMENTS < 32767) ? MAX_ELEMENTS : 32767;
  localparam int RANDOM_PER_PHASE = 20;
  localparam int DRAIN_CYCLES     = 50;
  localparam longint CYCLE_LIMIT  = 10_000_000;

  typedef struct {
    logic [31:0] value;
    logic        last;
  } request_t;

  typedef struct {
    logic             is_prime;
    logic [CNT_W-1:0] prime_count;
    logic             last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // [31:0] value
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [0] is_prime, [15:1] prime_count
  logic        m_tlast;

  request_t         pending_requests[$];
  result_t          results_due[$];
  logic [CNT_W-1:0] set_prime_count = '0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               mismatches = 0;
  longint           cycles = 0;

  prime_count_trial_division #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // trial division over odd divisors while divisor squared fits the value
  function automatic logic value_is_prime(logic [31:0] v);
    longint unsigned n;
    longint unsigned d;
    if (v[31]) return 1'b0;
    n = v;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d * d <= n; d += 2)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // expected result of one accepted request, and the count update
  task automatic predict_result(logic [31:0] value, logic last);
    result_t r;
    r.is_prime    = value_is_prime(value);
    r.prime_count = set_prime_count;
    if (r.is_prime && r.prime_count < COUNT_LIMIT)
      r.prime_count = r.prime_count + 1'b1;
    r.last = last;
    results_due.push_back(r);
    set_prime_count = last ? '0 : r.prime_count;
  endtask

  task automatic flag_error(string msg);
    if (mismatches < 10)
      $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic add_request(logic [31:0] value, logic last);
    request_t q;
    q.value = value;
    q.last  = last;
    pending_requests.push_back(q);
  endtask

  // waits until every queued request went in and every result came out
  task automatic wait_quiet();
    while (pending_requests.size() != 0 || s_tvalid || results_due.size() != 0)
      @(posedge clk);
  endtask

  // random values kept cheap for the divisor loop, all bits still toggle
  function automatic logic [31:0] random_value();
    int unsigned pick;
    int unsigned f;
    int unsigned r;
    pick = $urandom_range(99);
    if (pick < 15) return {1'b1, 31'($urandom)};
    if (pick < 30) return $urandom & 32'h7FFF_FFFE;
    if (pick < 45) begin
      // odd multiple of a small prime: loop stops early
      case ($urandom_range(5))
        0: f = 3;
        1: f = 5;
        2: f = 7;
        3: f = 11;
        4: f = 13;
        default: f = 17;
      endcase
      r = 2 * $urandom_range(0, (32'h7FFF_FFFF / f - 1) / 2) + 1;
      return f * r;
    end
    if (pick < 75) return $urandom_range(3, 65535) | 1;
    if (pick < 92) return $urandom_range(0, 64);
    return $urandom_range(65536, 1 << 22) | 1;
  endfunction

  task automatic add_random_requests(int count);
    for (int i = 0; i < count; i++)
      add_request(random_value(), $urandom_range(5) == 0);
  endtask

  // cycle counter with run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** prime_count_trial_division: FAILED **");
      $finish;
    end
  end

  // request driver: holds a request until taken, idles at random
  always @(posedge clk) begin : drive_requests
    request_t q;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        q = pending_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= q.value;
        s_tlast  <= q.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        predict_result(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          flag_error($sformatf("unexpected result prime=%0b count=%0d last=%0b",
                               m_tdata[0], m_tdata[15:1], m_tlast));
        end else begin
          want = results_due.pop_front();
          if (m_tdata[0] !== want.is_prime || m_tdata[15:1] !== want.prime_count ||
              m_tlast !== want.last)
            flag_error($sformatf("expected prime=%0b count=%0d last=%0b, got %0b %0d %0b",
                                 want.is_prime, want.prime_count, want.last,
                                 m_tdata[0], m_tdata[15:1], m_tlast));
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed corners, no idling
    add_request(32'd0, 1'b0);
    add_request(32'd1, 1'b0);
    add_request(32'd2, 1'b0);
    add_request(32'd3, 1'b0);
    add_request(32'd4, 1'b1);
    add_request(32'hFFFF_FFFF, 1'b0);          // minus one
    add_request(32'h8000_0000, 1'b0);          // most negative
    add_request(32'hFFFF_FFFD, 1'b0);          // minus three
    add_request(32'd9, 1'b0);                  // square of the first divisor
    add_request(32'd25, 1'b0);
    add_request(32'd63001, 1'b0);              // square of a prime
    add_request(32'd15, 1'b0);
    add_request(32'd97, 1'b1);
    add_request(32'd5, 1'b1);                  // set of one
    add_request(32'd65521, 1'b0);
    add_request(32'h7FFF_FFFE, 1'b0);          // largest even
    add_request(32'h7FFF_FFFF, 1'b0);          // largest positive, prime
    add_request(32'hAAAA_AAAB, 1'b0);
    add_request(32'h5555_5555, 1'b0);
    add_request(32'd7, 1'b0);
    add_request(32'd8, 1'b1);                  // last on a non-prime
    wait_quiet();

    // random requests under each idle mix
    add_random_requests(RANDOM_PER_PHASE);
    wait_quiet();
    send_idle_pct = 68;
    add_random_requests(RANDOM_PER_PHASE);
    wait_quiet();
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    add_random_requests(RANDOM_PER_PHASE);
    wait_quiet();
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    add_random_requests(RANDOM_PER_PHASE);
    wait_quiet();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", results_due.size()));
    if (mismatches == 0) begin
      $display("** prime_count_trial_division: PASSED **");
    end else begin
      $display("** prime_count_trial_division: FAILED **");
    end
    $finish;
  end

endmodule
